// ===== sv/grid_word_search_unit_defines.svh =====
// Assertion macros shared by the checker of the grid word search unit.
`ifndef GRID_WORD_SEARCH_UNIT_DEFINES_SVH
`define GRID_WORD_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gws_pkg.sv =====
// Shared types and constants of the grid word search unit.
package gws_pkg;

  localparam int GRID_SIZE_W = 7;
  localparam int WORD_LEN_W  = 4;
  localparam int CHAR_W      = 8;
  localparam int COORD_W     = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int TOTAL_W     = 2 * GRID_SIZE_W;
  localparam int HIGH_CHAR0  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd3;

  // One search job: effective grid side and word length.
  typedef struct packed {
    logic [GRID_SIZE_W-1:0] size;
    logic [WORD_LEN_W-1:0]  len;
  } job_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_DIR,
    ENG_READ,
    ENG_CMP,
    ENG_DONE
  } eng_state_t;

endpackage

// ===== sv/gws_queue.sv =====
// Two-entry job queue between the loader and the search engine.
module gws_queue
  import gws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic not_empty
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign do_push   = push && (count_r != 2'd2);
  assign do_pop    = pop && (count_r != 2'd0);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/gws_front.sv =====
// Cell loader: counts incoming cells, writes them to the grid store, issues jobs.
module gws_front
  import gws_pkg::*;
#(
  parameter int GRID_MAX = 64,
  parameter int WORD_MAX = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [CHAR_W-1:0]              cell_char,
  input  logic [GRID_SIZE_W-1:0]         grid_size,
  input  logic [WORD_LEN_W-1:0]          word_length,
  output logic                           wr_en,
  output logic [$clog2(GRID_MAX*GRID_MAX)-1:0] wr_addr,
  output logic [CHAR_W-1:0]              wr_data,
  output logic                           job_push,
  output job_t                           job
);

  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int CMPW  = (CNTW > TOTAL_W) ? CNTW : TOTAL_W;

  logic [CNTW-1:0]        cnt_r, cnt_nxt, cnt_inc;
  logic [GRID_SIZE_W-1:0] eff_size;
  logic [WORD_LEN_W-1:0]  eff_len;
  logic [TOTAL_W-1:0]     total;
  logic                   grid_done;

  // clamp configured values into their legal ranges
  always_comb begin
    priority if (grid_size == '0) begin
      eff_size = GRID_SIZE_W'(1);
    end else if (int'(grid_size) > GRID_MAX) begin
      eff_size = GRID_SIZE_W'(GRID_MAX);
    end else begin
      eff_size = grid_size;
    end
    priority if (word_length == '0) begin
      eff_len = WORD_LEN_W'(1);
    end else if (int'(word_length) > WORD_MAX) begin
      eff_len = WORD_LEN_W'(WORD_MAX);
    end else begin
      eff_len = word_length;
    end
  end

  assign total     = TOTAL_W'(eff_size) * TOTAL_W'(eff_size);
  assign cnt_inc   = cnt_r + CNTW'(1);
  assign grid_done = CMPW'(cnt_inc) >= CMPW'(total);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = grid_done ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign wr_en    = accept && (int'(cnt_r) < DEPTH);
  assign wr_addr  = cnt_r[AW-1:0];
  assign wr_data  = cell_char;
  assign job_push = accept && grid_done;
  assign job      = '{size: eff_size, len: eff_len};

endmodule

// ===== sv/gws_engine.sv =====
// Search engine: grid store plus a sequencer that walks start cells and directions.
module gws_engine
  import gws_pkg::*;
#(
  parameter int GRID_MAX = 64,
  parameter int WORD_MAX = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  input  job_t                                 job,
  output logic                                 job_pop,
  input  logic                                 wr_en,
  input  logic [$clog2(GRID_MAX*GRID_MAX)-1:0] wr_addr,
  input  logic [CHAR_W-1:0]                    wr_data,
  input  logic [WORD_MAX-1:0][CHAR_W-1:0]      word,
  output logic                                 eng_busy,
  output logic                                 out_strobe,
  output logic                                 out_found,
  output logic [COORD_W-1:0]                   out_start_row,
  output logic [COORD_W-1:0]                   out_start_col,
  output logic [COORD_W-1:0]                   out_end_row,
  output logic [COORD_W-1:0]                   out_end_col
);

  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_MAX);
  localparam int XW    = ((CW > GRID_SIZE_W) ? CW : GRID_SIZE_W) + 2;
  localparam int KW    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

  logic [CHAR_W-1:0] mem [DEPTH];

  eng_state_t             state_r, state_nxt;
  logic [GRID_SIZE_W-1:0] n_r, n_nxt;
  logic [WORD_LEN_W-1:0]  lm1_r, lm1_nxt;
  logic [WORD_LEN_W-1:0]  k_r, k_nxt;
  logic [CW-1:0]          row_r, row_nxt, col_r, col_nxt;
  dir_t                   dir_r, dir_nxt;
  logic [AW-1:0]          start_addr_r, start_addr_nxt;
  logic [AW-1:0]          pos_r, pos_nxt, pos_step;
  logic [CHAR_W-1:0]      rd_data_r;
  logic                   found_r, found_nxt;
  logic [COORD_W-1:0]     sr_r, sr_nxt, sc_r, sc_nxt, er_r, er_nxt, ec_r, ec_nxt;

  logic [XW-1:0] row_x, col_x, n_x, lm1_x, end_row_x, end_col_x;
  logic          feasible, last_col, last_try, char_match, last_char;

  assign row_x = XW'(row_r);
  assign col_x = XW'(col_r);
  assign n_x   = XW'(n_r);
  assign lm1_x = XW'(lm1_r);

  assign last_col   = (col_x == n_x - XW'(1));
  assign last_try   = (dir_r == DIR_DOWN) && last_col && (row_x == n_x - XW'(1));
  assign char_match = (rd_data_r == word[k_r[KW-1:0]]);
  assign last_char  = (k_r == lm1_r);

  // the path stays inside the grid exactly when its far end does
  always_comb begin
    unique case (dir_r)
      DIR_RIGHT: begin
        feasible  = (col_x + lm1_x) < n_x;
        end_row_x = row_x;
        end_col_x = col_x + lm1_x;
        pos_step  = pos_r + AW'(1);
      end
      DIR_LEFT: begin
        feasible  = col_x >= lm1_x;
        end_row_x = row_x;
        end_col_x = col_x - lm1_x;
        pos_step  = pos_r - AW'(1);
      end
      DIR_UP: begin
        feasible  = row_x >= lm1_x;
        end_row_x = row_x - lm1_x;
        end_col_x = col_x;
        pos_step  = pos_r - AW'(n_r);
      end
      DIR_DOWN: begin
        feasible  = (row_x + lm1_x) < n_x;
        end_row_x = row_x + lm1_x;
        end_col_x = col_x;
        pos_step  = pos_r + AW'(n_r);
      end
      default: begin
        feasible  = 1'b0;
        end_row_x = row_x;
        end_col_x = col_x;
        pos_step  = pos_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (job_valid) state_nxt = ENG_DIR;
      end
      ENG_DIR: begin
        priority if (feasible) state_nxt = ENG_READ;
        else if (last_try)     state_nxt = ENG_DONE;
        else                   state_nxt = ENG_DIR;
      end
      ENG_READ: begin
        state_nxt = ENG_CMP;
      end
      ENG_CMP: begin
        priority if (char_match && last_char) state_nxt = ENG_DONE;
        else if (char_match)                  state_nxt = ENG_READ;
        else if (last_try)                    state_nxt = ENG_DONE;
        else                                  state_nxt = ENG_DIR;
      end
      ENG_DONE: begin
        state_nxt = ENG_IDLE;
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    logic move_on;
    move_on        = 1'b0;
    n_nxt          = n_r;
    lm1_nxt        = lm1_r;
    k_nxt          = k_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    dir_nxt        = dir_r;
    start_addr_nxt = start_addr_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    er_nxt         = er_r;
    ec_nxt         = ec_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (job_valid) begin
          n_nxt          = job.size;
          lm1_nxt        = job.len - WORD_LEN_W'(1);
          row_nxt        = '0;
          col_nxt        = '0;
          dir_nxt        = DIR_RIGHT;
          start_addr_nxt = '0;
          found_nxt      = 1'b0;
          sr_nxt         = '0;
          sc_nxt         = '0;
          er_nxt         = '0;
          ec_nxt         = '0;
        end
      end
      ENG_DIR: begin
        if (feasible) begin
          pos_nxt = start_addr_r;
          k_nxt   = '0;
        end else begin
          move_on = 1'b1;
        end
      end
      ENG_CMP: begin
        priority if (char_match && last_char) begin
          found_nxt = 1'b1;
          sr_nxt    = COORD_W'(row_r);
          sc_nxt    = COORD_W'(col_r);
          er_nxt    = COORD_W'(end_row_x);
          ec_nxt    = COORD_W'(end_col_x);
        end else if (char_match) begin
          k_nxt   = k_r + WORD_LEN_W'(1);
          pos_nxt = pos_step;
        end else begin
          move_on = 1'b1;
        end
      end
      ENG_READ, ENG_DONE: begin
      end
      default: begin
      end
    endcase
    // next direction, or next start cell in row-major order
    if (move_on && !last_try) begin
      if (dir_r != DIR_DOWN) begin
        dir_nxt = dir_t'(dir_r + 2'd1);
      end else begin
        dir_nxt        = DIR_RIGHT;
        start_addr_nxt = start_addr_r + AW'(1);
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    lm1_r        <= lm1_nxt;
    k_r          <= k_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    dir_r        <= dir_nxt;
    start_addr_r <= start_addr_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    sr_r         <= sr_nxt;
    sc_r         <= sc_nxt;
    er_r         <= er_nxt;
    ec_r         <= ec_nxt;
  end

  // grid store: one write port from the loader, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[pos_r];
  end

  // outputs
  always_comb begin
    job_pop       = (state_r == ENG_IDLE) && job_valid;
    eng_busy      = (state_r != ENG_IDLE);
    out_strobe    = (state_r == ENG_DONE);
    out_found     = found_r;
    out_start_row = sr_r;
    out_start_col = sc_r;
    out_end_row   = er_r;
    out_end_col   = ec_r;
  end

endmodule

// ===== sv/grid_word_search_unit.sv =====
// Top level of the grid word search unit: config registers, loader, job queue, engine.
//
// Usage
//   Configure grid_size (index 0), word_length (1), word characters 0..7 (2) and
//   8..14 (3) through cfg_we/cfg_index/cfg_data; writes take effect at once.
//   Then stream the grid cells in row-major order on in_cell_char: a transaction
//   is accepted at each clock edge where start is high and busy is low.
//   The loader takes one cell per cycle while busy is low; busy stays low while the grid fills.
//   The transaction carrying the last cell queues a search job and raises busy.
//   The engine tries start cells in row-major order and, per cell, the
//   directions right, left, up, down, and stops at the first hit. For each
//   direction it checks that the path fits, then for each character reads the
//   registered grid store and compares. The engine picks up the job before the
//   search and shows the result in a state of its own; the store has one read port.
//   The result is shown for exactly one cycle with out_strobe high; the receiver
//   must take it then, it cannot stall. busy drops in the following cycle.
//   Not found: out_found low and all coordinates zero.
//   Reset (rst_n low, synchronous) empties the queue, idles the engine, clears
//   the cell count and restores default config; grid contents are not cleared.
module grid_word_search_unit
  import gws_pkg::*;
#(
  parameter int GRID_MAX = 64,
  parameter int WORD_MAX = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cell input channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CHAR_W-1:0]     in_cell_char,
  // result channel
  output logic                  out_strobe,
  output logic                  out_found,
  output logic [COORD_W-1:0]    out_start_row,
  output logic [COORD_W-1:0]    out_start_col,
  output logic [COORD_W-1:0]    out_end_row,
  output logic [COORD_W-1:0]    out_end_col,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(GRID_MAX * GRID_MAX);

  logic [GRID_SIZE_W-1:0]          grid_size_r;
  logic [WORD_LEN_W-1:0]           word_length_r;
  logic [WORD_MAX-1:0][CHAR_W-1:0] word_r;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic          job_push, job_pop, job_valid, eng_busy;
  job_t          push_job, head_job;

  // busy while any job is queued or the engine is running
  assign busy   = job_valid || eng_busy;
  assign accept = start && !busy;

  // Config registers. Characters past WORD_MAX are never compared, so not kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r   <= GRID_SIZE_W'(1);
      word_length_r <= WORD_LEN_W'(1);
      word_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIZE: grid_size_r   <= cfg_data[GRID_SIZE_W-1:0];
        REG_WORD_LEN:  word_length_r <= cfg_data[WORD_LEN_W-1:0];
        REG_CHARS_LOW: begin
          for (int i = 0; (i < WORD_MAX) && (i < HIGH_CHAR0); i++) begin
            word_r[i] <= cfg_data[CHAR_W*i +: CHAR_W];
          end
        end
        REG_CHARS_HIGH: begin
          for (int i = HIGH_CHAR0; i < WORD_MAX; i++) begin
            word_r[i] <= cfg_data[CHAR_W*(i-HIGH_CHAR0) +: CHAR_W];
          end
        end
        default: begin
        end
      endcase
    end
  end

  gws_front #(
    .GRID_MAX (GRID_MAX),
    .WORD_MAX (WORD_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cell_char   (in_cell_char),
    .grid_size   (grid_size_r),
    .word_length (word_length_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_push    (job_push),
    .job         (push_job)
  );

  gws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .head_job  (head_job),
    .not_empty (job_valid)
  );

  gws_engine #(
    .GRID_MAX (GRID_MAX),
    .WORD_MAX (WORD_MAX)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job           (head_job),
    .job_pop       (job_pop),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .word          (word_r),
    .eng_busy      (eng_busy),
    .out_strobe    (out_strobe),
    .out_found     (out_found),
    .out_start_row (out_start_row),
    .out_start_col (out_start_col),
    .out_end_row   (out_end_row),
    .out_end_col   (out_end_col)
  );

endmodule

// ===== sv/gws_checker.sv =====
// Port-level checker for the grid word search unit, bound to the top level.
`include "grid_word_search_unit_defines.svh"

module gws_checker
  import gws_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input logic               out_found,
  input logic [COORD_W-1:0] out_start_row,
  input logic [COORD_W-1:0] out_start_col,
  input logic [COORD_W-1:0] out_end_row,
  input logic [COORD_W-1:0] out_end_col
);

  // a result is a single-cycle strobe
  `GWS_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held over two cycles")

  // a result only shows up while a search is in progress
  `GWS_ASSERT_NOW(a_strobe_busy, out_strobe, busy, "result strobe while not busy")

  // a miss reports all coordinates zero
  `GWS_ASSERT_NOW(a_miss_zero, out_strobe && !out_found, (out_start_row == '0) && (out_start_col == '0) && (out_end_row == '0) && (out_end_col == '0), "miss with nonzero coordinates")

  // a hit lies on one row or one column
  `GWS_ASSERT_NOW(a_hit_line, out_strobe && out_found, (out_start_row == out_end_row) || (out_start_col == out_end_col), "hit not along a row or column")

endmodule

bind grid_word_search_unit gws_checker u_gws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_found     (out_found),
  .out_start_row (out_start_row),
  .out_start_col (out_start_col),
  .out_end_row   (out_end_row),
  .out_end_col   (out_end_col)
);
